// ===== src/bfbm_pkg.sv =====
// bfbm_pkg: shared types, codes and constants of the box filter core.
// Used by every module under src except bfbm_ram; depends on nothing.

package bfbm_pkg;

   // defaults for the top-level parameters
   localparam int MAX_ROWS_DEF   = 256;
   localparam int MAX_COLS_DEF   = 256;
   localparam int PIXEL_BITS_DEF = 16;
   localparam int MAX_RADIUS_DEF = 4;

   // fixed field widths
   localparam int OPCODE_W   = 1;
   localparam int INDEX_W    = 8;
   localparam int PIXEL_IN_W = 16;
   localparam int OUT_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam int COUNT_W    = 9;
   localparam int RAD_W      = 3;
   localparam int MODE_W     = 2;
   localparam int STEP_W     = 4;

   // opcodes
   localparam logic [OPCODE_W-1:0] OPC_WRITE = 1'b0;
   localparam logic [OPCODE_W-1:0] OPC_QUERY = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_RADIUS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BORDER_MODE   = 2'd3;

   // register reset values
   localparam logic [COUNT_W-1:0] ROW_COUNT_RST     = 9'd256;
   localparam logic [COUNT_W-1:0] COL_COUNT_RST     = 9'd256;
   localparam logic [RAD_W-1:0]   KERNEL_RADIUS_RST = 3'd1;
   localparam logic [MODE_W-1:0]  BORDER_MODE_RST   = 2'd0;

   // border modes; the unused code behaves as zero fill
   localparam logic [MODE_W-1:0] BORDER_ZERO = 2'd0;
   localparam logic [MODE_W-1:0] BORDER_WRAP = 2'd1;
   localparam logic [MODE_W-1:0] BORDER_EDGE = 2'd2;

   // window areas for radius 1..4
   localparam int AREA_R1 = 9;
   localparam int AREA_R2 = 25;
   localparam int AREA_R3 = 49;
   localparam int AREA_R4 = 81;

   // datapath operation of one microcode step
   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_LATCH = 3'd1,
      OP_BACK  = 3'd2,
      OP_READ  = 3'd3,
      OP_WRITE = 3'd4,
      OP_EMIT  = 3'd5
   } bfbm_op_type;

   // jump condition of one microcode step
   typedef enum logic [2:0] {
      COND_NEVER     = 3'd0,
      COND_ALWAYS    = 3'd1,
      COND_NO_START  = 3'd2,
      COND_IS_WRITE  = 3'd3,
      COND_OUTSIDE   = 3'd4,
      COND_K_NOT_ONE = 3'd5,
      COND_NOT_LAST  = 3'd6
   } bfbm_cond_type;

   // microprogram addresses
   typedef enum logic [STEP_W-1:0] {
      STEP_IDLE      = 4'd0,
      STEP_DISPATCH  = 4'd1,
      STEP_CHECK     = 4'd2,
      STEP_BACK      = 4'd3,
      STEP_READ      = 4'd4,
      STEP_DRAIN_MUL = 4'd5,
      STEP_DRAIN_ACC = 4'd6,
      STEP_EMIT      = 4'd7,
      STEP_WRITE     = 4'd8
   } bfbm_step_type;

   typedef struct packed {
      bfbm_op_type   op;
      bfbm_cond_type cond;
      bfbm_step_type target;
   } bfbm_ctrl_type;

   typedef struct packed {
      logic is_write;
      logic outside;
      logic k_not_one;
      logic not_last;
   } bfbm_status_type;

endpackage

// ===== src/bfbm_ram.sv =====
// bfbm_ram: generic single-port RAM, one write and one registered read per cycle.
// No dependencies.

module bfbm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/bfbm_seq.sv =====
// bfbm_seq: microprogram ROM, step counter and jump logic.
// Depends on bfbm_pkg.

module bfbm_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  bfbm_pkg::bfbm_status_type status,
   output bfbm_pkg::bfbm_ctrl_type   ctrl,
   output logic                     busy
);

   bfbm_pkg::bfbm_step_type pc_ff, pc_in;
   logic                    taken;

   // microprogram ROM
   always_comb begin
      unique case (pc_ff)
         bfbm_pkg::STEP_IDLE:
            ctrl = '{bfbm_pkg::OP_LATCH, bfbm_pkg::COND_NO_START, bfbm_pkg::STEP_IDLE};
         bfbm_pkg::STEP_DISPATCH:
            ctrl = '{bfbm_pkg::OP_NONE, bfbm_pkg::COND_IS_WRITE, bfbm_pkg::STEP_WRITE};
         bfbm_pkg::STEP_CHECK:
            ctrl = '{bfbm_pkg::OP_NONE, bfbm_pkg::COND_OUTSIDE, bfbm_pkg::STEP_EMIT};
         bfbm_pkg::STEP_BACK:
            ctrl = '{bfbm_pkg::OP_BACK, bfbm_pkg::COND_K_NOT_ONE, bfbm_pkg::STEP_BACK};
         bfbm_pkg::STEP_READ:
            ctrl = '{bfbm_pkg::OP_READ, bfbm_pkg::COND_NOT_LAST, bfbm_pkg::STEP_READ};
         bfbm_pkg::STEP_DRAIN_MUL:
            ctrl = '{bfbm_pkg::OP_NONE, bfbm_pkg::COND_NEVER, bfbm_pkg::STEP_IDLE};
         bfbm_pkg::STEP_DRAIN_ACC:
            ctrl = '{bfbm_pkg::OP_NONE, bfbm_pkg::COND_NEVER, bfbm_pkg::STEP_IDLE};
         bfbm_pkg::STEP_EMIT:
            ctrl = '{bfbm_pkg::OP_EMIT, bfbm_pkg::COND_ALWAYS, bfbm_pkg::STEP_IDLE};
         bfbm_pkg::STEP_WRITE:
            ctrl = '{bfbm_pkg::OP_WRITE, bfbm_pkg::COND_ALWAYS, bfbm_pkg::STEP_IDLE};
         default:
            ctrl = '{bfbm_pkg::OP_NONE, bfbm_pkg::COND_ALWAYS, bfbm_pkg::STEP_IDLE};
      endcase
   end

   // next step
   always_comb begin
      unique case (ctrl.cond)
         bfbm_pkg::COND_NEVER:     taken = 1'b0;
         bfbm_pkg::COND_ALWAYS:    taken = 1'b1;
         bfbm_pkg::COND_NO_START:  taken = !start;
         bfbm_pkg::COND_IS_WRITE:  taken = status.is_write;
         bfbm_pkg::COND_OUTSIDE:   taken = status.outside;
         bfbm_pkg::COND_K_NOT_ONE: taken = status.k_not_one;
         bfbm_pkg::COND_NOT_LAST:  taken = status.not_last;
         default:                  taken = 1'b1;
      endcase
      if (taken) begin
         pc_in = ctrl.target;
      end else begin
         pc_in = bfbm_pkg::bfbm_step_type'(pc_ff + 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= bfbm_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign busy = (pc_ff != bfbm_pkg::STEP_IDLE);

endmodule

// ===== src/bfbm_dp.sv =====
// bfbm_dp: config registers, window walk, address forming, divide and sum.
// Depends on bfbm_pkg; driven by bfbm_seq, reads and writes bfbm_ram.

module bfbm_dp #(
   parameter int MAX_ROWS   = bfbm_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS   = bfbm_pkg::MAX_COLS_DEF,
   parameter int PIXEL_BITS = bfbm_pkg::PIXEL_BITS_DEF,
   parameter int MAX_RADIUS = bfbm_pkg::MAX_RADIUS_DEF,
   localparam int ADDR_W    = $clog2(MAX_ROWS * MAX_COLS)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [bfbm_pkg::OPCODE_W-1:0]       req_opcode,
   input  logic [bfbm_pkg::INDEX_W-1:0]        req_row_index,
   input  logic [bfbm_pkg::INDEX_W-1:0]        req_col_index,
   input  logic [bfbm_pkg::PIXEL_IN_W-1:0]     req_pixel_value,
   input  logic                                csr_write_enable,
   input  logic [bfbm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bfbm_pkg::CSR_DATA_W-1:0]     csr_data,
   input  bfbm_pkg::bfbm_ctrl_type             ctrl,
   output bfbm_pkg::bfbm_status_type           status,
   output logic                                ram_we,
   output logic                                ram_re,
   output logic [ADDR_W-1:0]                   ram_addr,
   output logic [PIXEL_BITS-1:0]               ram_wdata,
   input  logic [PIXEL_BITS-1:0]               ram_rdata,
   output logic                                rsp_strobe,
   output logic [bfbm_pkg::OUT_W-1:0]          rsp_filtered_value
);

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int NR_W   = $clog2(MAX_ROWS + 1);
   localparam int NC_W   = $clog2(MAX_COLS + 1);
   localparam int RAW_RW = $clog2(MAX_ROWS + MAX_RADIUS + 1) + 1;
   localparam int RAW_CW = $clog2(MAX_COLS + MAX_RADIUS + 1) + 1;
   localparam int PROD_W = 2 * PIXEL_BITS + 1;
   localparam int ACC_W  = (PIXEL_BITS + 7 > bfbm_pkg::OUT_W) ? PIXEL_BITS + 7
                                                               : bfbm_pkg::OUT_W;
   localparam int RAD_W  = bfbm_pkg::RAD_W;

   // reciprocals ceil(2^(PIXEL_BITS+s)/area), s = clog2(area); exact for all pixels
   localparam int SH1 = PIXEL_BITS + $clog2(bfbm_pkg::AREA_R1);
   localparam int SH2 = PIXEL_BITS + $clog2(bfbm_pkg::AREA_R2);
   localparam int SH3 = PIXEL_BITS + $clog2(bfbm_pkg::AREA_R3);
   localparam int SH4 = PIXEL_BITS + $clog2(bfbm_pkg::AREA_R4);
   localparam logic [63:0] RECIP1_WIDE =
      ((64'd1 << SH1) + 64'(bfbm_pkg::AREA_R1 - 1)) / 64'(bfbm_pkg::AREA_R1);
   localparam logic [63:0] RECIP2_WIDE =
      ((64'd1 << SH2) + 64'(bfbm_pkg::AREA_R2 - 1)) / 64'(bfbm_pkg::AREA_R2);
   localparam logic [63:0] RECIP3_WIDE =
      ((64'd1 << SH3) + 64'(bfbm_pkg::AREA_R3 - 1)) / 64'(bfbm_pkg::AREA_R3);
   localparam logic [63:0] RECIP4_WIDE =
      ((64'd1 << SH4) + 64'(bfbm_pkg::AREA_R4 - 1)) / 64'(bfbm_pkg::AREA_R4);
   localparam logic [PIXEL_BITS:0] RECIP1 = RECIP1_WIDE[PIXEL_BITS:0];
   localparam logic [PIXEL_BITS:0] RECIP2 = RECIP2_WIDE[PIXEL_BITS:0];
   localparam logic [PIXEL_BITS:0] RECIP3 = RECIP3_WIDE[PIXEL_BITS:0];
   localparam logic [PIXEL_BITS:0] RECIP4 = RECIP4_WIDE[PIXEL_BITS:0];

   // config registers
   logic [bfbm_pkg::COUNT_W-1:0] row_count_ff, row_count_in;
   logic [bfbm_pkg::COUNT_W-1:0] col_count_ff, col_count_in;
   logic [RAD_W-1:0]             kernel_radius_ff, kernel_radius_in;
   logic [bfbm_pkg::MODE_W-1:0]  border_mode_ff, border_mode_in;

   // latched word
   logic [bfbm_pkg::OPCODE_W-1:0]   opcode_ff, opcode_in;
   logic [bfbm_pkg::INDEX_W-1:0]    row_ff, row_in;
   logic [bfbm_pkg::INDEX_W-1:0]    col_ff, col_in;
   logic [bfbm_pkg::PIXEL_IN_W-1:0] pixel_ff, pixel_in;

   // window walk
   logic signed [RAW_RW-1:0] raw_r_ff, raw_r_in, r_end_ff, r_end_in;
   logic signed [RAW_CW-1:0] raw_c_ff, raw_c_in, c_end_ff, c_end_in;
   logic signed [RAW_CW-1:0] raw_c0_ff, raw_c0_in;
   logic [ROW_W-1:0]         wrap_r_ff, wrap_r_in;
   logic [COL_W-1:0]         wrap_c_ff, wrap_c_in, wrap_c0_ff, wrap_c0_in;
   logic [RAD_W-1:0]         k_ff, k_in;

   // divide and sum pipeline
   logic                v1_ff, v1_in, v2_ff, v2_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;

   logic [NR_W-1:0]          nr;
   logic [NC_W-1:0]          nc;
   logic [RAD_W-1:0]         rad;
   logic signed [RAW_RW-1:0] nr_s, row_s, rad_rs;
   logic signed [RAW_CW-1:0] nc_s, col_s, rad_cs;
   logic [ROW_W-1:0]         wrap_r_inc, wrap_r_dec, edge_r, eff_r;
   logic [COL_W-1:0]         wrap_c_inc, wrap_c_dec, edge_c, eff_c;
   logic                     in_frame, sample_ok, outside, latch_en;
   logic [PIXEL_BITS:0]      recip;
   logic [PIXEL_BITS-1:0]    quo;

   // effective frame size and radius
   always_comb begin
      if (row_count_ff == '0) begin
         nr = NR_W'(1);
      end else if (32'(row_count_ff) > MAX_ROWS) begin
         nr = NR_W'(MAX_ROWS);
      end else begin
         nr = NR_W'(row_count_ff);
      end
      if (col_count_ff == '0) begin
         nc = NC_W'(1);
      end else if (32'(col_count_ff) > MAX_COLS) begin
         nc = NC_W'(MAX_COLS);
      end else begin
         nc = NC_W'(col_count_ff);
      end
      if (kernel_radius_ff == '0) begin
         rad = RAD_W'(1);
      end else if (32'(kernel_radius_ff) > MAX_RADIUS) begin
         rad = RAD_W'(MAX_RADIUS);
      end else begin
         rad = kernel_radius_ff;
      end
   end

   assign nr_s   = RAW_RW'($signed({1'b0, nr}));
   assign nc_s   = RAW_CW'($signed({1'b0, nc}));
   assign row_s  = RAW_RW'($signed({1'b0, req_row_index}));
   assign col_s  = RAW_CW'($signed({1'b0, req_col_index}));
   assign rad_rs = RAW_RW'($signed({1'b0, rad}));
   assign rad_cs = RAW_CW'($signed({1'b0, rad}));

   assign outside = (32'(row_ff) >= 32'(nr)) || (32'(col_ff) >= 32'(nc));
   assign latch_en = (ctrl.op == bfbm_pkg::OP_LATCH) && start;

   // wrap counters track each coordinate modulo the frame size
   assign wrap_r_inc = (NR_W'(wrap_r_ff) == nr - NR_W'(1)) ? '0 : wrap_r_ff + ROW_W'(1);
   assign wrap_r_dec = (wrap_r_ff == '0) ? ROW_W'(nr - NR_W'(1)) : wrap_r_ff - ROW_W'(1);
   assign wrap_c_inc = (NC_W'(wrap_c_ff) == nc - NC_W'(1)) ? '0 : wrap_c_ff + COL_W'(1);
   assign wrap_c_dec = (wrap_c_ff == '0) ? COL_W'(nc - NC_W'(1)) : wrap_c_ff - COL_W'(1);

   // nearest edge clamp
   always_comb begin
      if (raw_r_ff < 0) begin
         edge_r = '0;
      end else if (raw_r_ff >= nr_s) begin
         edge_r = ROW_W'(nr - NR_W'(1));
      end else begin
         edge_r = ROW_W'(raw_r_ff);
      end
      if (raw_c_ff < 0) begin
         edge_c = '0;
      end else if (raw_c_ff >= nc_s) begin
         edge_c = COL_W'(nc - NC_W'(1));
      end else begin
         edge_c = COL_W'(raw_c_ff);
      end
   end

   assign in_frame = (raw_r_ff >= 0) && (raw_r_ff < nr_s)
                     && (raw_c_ff >= 0) && (raw_c_ff < nc_s);

   always_comb begin
      unique case (border_mode_ff)
         bfbm_pkg::BORDER_WRAP: begin
            eff_r     = wrap_r_ff;
            eff_c     = wrap_c_ff;
            sample_ok = 1'b1;
         end
         bfbm_pkg::BORDER_EDGE: begin
            eff_r     = edge_r;
            eff_c     = edge_c;
            sample_ok = 1'b1;
         end
         default: begin
            eff_r     = ROW_W'(raw_r_ff);
            eff_c     = COL_W'(raw_c_ff);
            sample_ok = in_frame;
         end
      endcase
   end

   // frame memory port
   always_comb begin
      ram_we    = (ctrl.op == bfbm_pkg::OP_WRITE) && !outside;
      ram_re    = (ctrl.op == bfbm_pkg::OP_READ);
      ram_wdata = PIXEL_BITS'(pixel_ff);
      if (ctrl.op == bfbm_pkg::OP_WRITE) begin
         ram_addr = ADDR_W'(ROW_W'(row_ff)) * ADDR_W'(MAX_COLS) + ADDR_W'(COL_W'(col_ff));
      end else begin
         ram_addr = ADDR_W'(eff_r) * ADDR_W'(MAX_COLS) + ADDR_W'(eff_c);
      end
   end

   // reciprocal and shift by window area
   always_comb begin
      unique case (rad)
         3'd2: begin
            recip = RECIP2;
            quo   = PIXEL_BITS'(prod_ff >> SH2);
         end
         3'd3: begin
            recip = RECIP3;
            quo   = PIXEL_BITS'(prod_ff >> SH3);
         end
         3'd4: begin
            recip = RECIP4;
            quo   = PIXEL_BITS'(prod_ff >> SH4);
         end
         default: begin
            recip = RECIP1;
            quo   = PIXEL_BITS'(prod_ff >> SH1);
         end
      endcase
   end

   // config writes
   always_comb begin
      row_count_in     = row_count_ff;
      col_count_in     = col_count_ff;
      kernel_radius_in = kernel_radius_ff;
      border_mode_in   = border_mode_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            bfbm_pkg::CSR_ROW_COUNT:     row_count_in     = csr_data;
            bfbm_pkg::CSR_COL_COUNT:     col_count_in     = csr_data;
            bfbm_pkg::CSR_KERNEL_RADIUS: kernel_radius_in = csr_data[RAD_W-1:0];
            bfbm_pkg::CSR_BORDER_MODE:   border_mode_in   = csr_data[bfbm_pkg::MODE_W-1:0];
            default:                     row_count_in     = row_count_ff;
         endcase
      end
   end

   // word latch and window walk
   always_comb begin
      opcode_in  = opcode_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      pixel_in   = pixel_ff;
      raw_r_in   = raw_r_ff;
      raw_c_in   = raw_c_ff;
      raw_c0_in  = raw_c0_ff;
      r_end_in   = r_end_ff;
      c_end_in   = c_end_ff;
      wrap_r_in  = wrap_r_ff;
      wrap_c_in  = wrap_c_ff;
      wrap_c0_in = wrap_c0_ff;
      k_in       = k_ff;
      unique case (ctrl.op)
         bfbm_pkg::OP_LATCH: begin
            if (start) begin
               opcode_in = req_opcode;
               row_in    = req_row_index;
               col_in    = req_col_index;
               pixel_in  = req_pixel_value;
               raw_r_in  = row_s;
               raw_c_in  = col_s;
               r_end_in  = row_s + rad_rs;
               c_end_in  = col_s + rad_cs;
               wrap_r_in = ROW_W'(req_row_index);
               wrap_c_in = COL_W'(req_col_index);
               k_in      = rad;
            end
         end
         bfbm_pkg::OP_BACK: begin
            // step to the top left corner; last step leaves the row start
            raw_r_in   = raw_r_ff - RAW_RW'(1);
            raw_c_in   = raw_c_ff - RAW_CW'(1);
            raw_c0_in  = raw_c_ff - RAW_CW'(1);
            wrap_r_in  = wrap_r_dec;
            wrap_c_in  = wrap_c_dec;
            wrap_c0_in = wrap_c_dec;
            k_in       = k_ff - RAD_W'(1);
         end
         bfbm_pkg::OP_READ: begin
            if (raw_c_ff == c_end_ff) begin
               raw_c_in  = raw_c0_ff;
               wrap_c_in = wrap_c0_ff;
               raw_r_in  = raw_r_ff + RAW_RW'(1);
               wrap_r_in = wrap_r_inc;
            end else begin
               raw_c_in  = raw_c_ff + RAW_CW'(1);
               wrap_c_in = wrap_c_inc;
            end
         end
         default: begin
            k_in = k_ff;
         end
      endcase
   end

   // read -> multiply -> shift and add
   always_comb begin
      v1_in   = (ctrl.op == bfbm_pkg::OP_READ) && sample_ok;
      v2_in   = v1_ff;
      prod_in = v1_ff ? PROD_W'(ram_rdata) * PROD_W'(recip) : '0;
      if (latch_en) begin
         acc_in = '0;
      end else if (v2_ff) begin
         acc_in = acc_ff + ACC_W'(quo);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff     <= bfbm_pkg::ROW_COUNT_RST;
         col_count_ff     <= bfbm_pkg::COL_COUNT_RST;
         kernel_radius_ff <= bfbm_pkg::KERNEL_RADIUS_RST;
         border_mode_ff   <= bfbm_pkg::BORDER_MODE_RST;
         v1_ff            <= 1'b0;
         v2_ff            <= 1'b0;
      end else begin
         row_count_ff     <= row_count_in;
         col_count_ff     <= col_count_in;
         kernel_radius_ff <= kernel_radius_in;
         border_mode_ff   <= border_mode_in;
         v1_ff            <= v1_in;
         v2_ff            <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      opcode_ff  <= opcode_in;
      row_ff     <= row_in;
      col_ff     <= col_in;
      pixel_ff   <= pixel_in;
      raw_r_ff   <= raw_r_in;
      raw_c_ff   <= raw_c_in;
      raw_c0_ff  <= raw_c0_in;
      r_end_ff   <= r_end_in;
      c_end_ff   <= c_end_in;
      wrap_r_ff  <= wrap_r_in;
      wrap_c_ff  <= wrap_c_in;
      wrap_c0_ff <= wrap_c0_in;
      k_ff       <= k_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
   end

   always_comb begin
      status.is_write  = (opcode_ff == bfbm_pkg::OPC_WRITE);
      status.outside   = outside;
      status.k_not_one = (k_ff != RAD_W'(1));
      status.not_last  = !((raw_r_ff == r_end_ff) && (raw_c_ff == c_end_ff));
   end

   assign rsp_strobe         = (ctrl.op == bfbm_pkg::OP_EMIT);
   assign rsp_filtered_value = acc_ff[bfbm_pkg::OUT_W-1:0];

endmodule

// ===== src/box_filter_border_modes_core.sv =====
// box_filter_border_modes_core: top level of the box filter over a stored frame.
// Depends on bfbm_pkg, bfbm_seq, bfbm_dp and bfbm_ram.
//
//   channel   ports                                    handshake
//   request   req_opcode/row_index/col_index/pixel_value  start && !busy
//   result    rsp_filtered_value                       rsp_strobe, one cycle
//   config    csr_index, csr_data                      csr_write_enable
//
// A write passes through the dispatch and write steps before the next accept.
// A query inside the frame reads its W*W window (W = 2*radius+1) in the read step:
// the frame memory port gives one window pixel per cycle, behind radius setup steps.
// A query outside the frame goes from the check step straight to the emit step and returns zero.
// The result shows on the cycle before busy drops; the receiver cannot stall it.
// Reset sets the sequencer and config registers to their reset values; frame contents stay undefined.

module box_filter_border_modes_core #(
   parameter int MAX_ROWS   = bfbm_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS   = bfbm_pkg::MAX_COLS_DEF,
   parameter int PIXEL_BITS = bfbm_pkg::PIXEL_BITS_DEF,
   parameter int MAX_RADIUS = bfbm_pkg::MAX_RADIUS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [bfbm_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [bfbm_pkg::INDEX_W-1:0]    req_row_index,
   input  logic [bfbm_pkg::INDEX_W-1:0]    req_col_index,
   input  logic [bfbm_pkg::PIXEL_IN_W-1:0] req_pixel_value,
   output logic                            rsp_strobe,
   output logic [bfbm_pkg::OUT_W-1:0]      rsp_filtered_value,
   input  logic                            csr_write_enable,
   input  logic [bfbm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bfbm_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = $clog2(DEPTH);

   bfbm_pkg::bfbm_ctrl_type   ctrl;
   bfbm_pkg::bfbm_status_type status;
   logic                      ram_we;
   logic                      ram_re;
   logic [ADDR_W-1:0]         ram_addr;
   logic [PIXEL_BITS-1:0]     ram_wdata;
   logic [PIXEL_BITS-1:0]     ram_rdata;

   bfbm_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   bfbm_dp #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .PIXEL_BITS (PIXEL_BITS),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .req_opcode         (req_opcode),
      .req_row_index      (req_row_index),
      .req_col_index      (req_col_index),
      .req_pixel_value    (req_pixel_value),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .ctrl               (ctrl),
      .status             (status),
      .ram_we             (ram_we),
      .ram_re             (ram_re),
      .ram_addr           (ram_addr),
      .ram_wdata          (ram_wdata),
      .ram_rdata          (ram_rdata),
      .rsp_strobe         (rsp_strobe),
      .rsp_filtered_value (rsp_filtered_value)
   );

   bfbm_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (DEPTH)
   ) u_frame (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

endmodule

// ===== src/bfbm_checker.sv =====
// bfbm_checker: port-level assertions on the box filter core, bound to the top level.
// Depends on bfbm_pkg and box_filter_border_modes_core.

module bfbm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [bfbm_pkg::OPCODE_W-1:0] req_opcode,
   input logic                          rsp_strobe
);

   // a result only comes while a word is in work
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   // the result closes the word
   a_strobe_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy)
      else $error("busy held after result");

   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == bfbm_pkg::OPC_WRITE)
         |=> (busy && !rsp_strobe) ##1 (busy && !rsp_strobe) ##1 !busy)
      else $error("write word misbehaved");

   a_query_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == bfbm_pkg::OPC_QUERY)
         |=> !rsp_strobe ##1 !rsp_strobe)
      else $error("query result too early");

endmodule

bind box_filter_border_modes_core bfbm_checker u_bfbm_checker (.*);
